// ===== design/id3_frame_text_rewriter_unit_assert.svh =====
// assertion macros for the frame rewriter checker
`ifndef ID3_FRAME_TEXT_REWRITER_UNIT_ASSERT_SVH
`define ID3_FRAME_TEXT_REWRITER_UNIT_ASSERT_SVH

// checked only out of reset
`define ID3FTR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every edge
`define ID3FTR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/id3ftr_pkg.sv =====
`default_nettype none

package id3ftr_pkg;

  localparam int TAG_HDR_LEN   = 10;
  localparam int FRAME_HDR_LEN = 10;
  localparam int MAX_TEXT_DEF  = 24;
  localparam int TEXT_SLOTS    = 24;
  localparam int CFG_AW        = 6;
  localparam int CFG_DW        = 64;

  localparam logic [31:0] TARGET_ID_RST = 32'h5449_5432;
  localparam logic [30:0] MAX_SIZE_RST  = 31'd1000000;
  localparam logic [7:0]  PAD_BYTE      = 8'h00;

  localparam logic [2:0] REG_TARGET_ID  = 3'd0;
  localparam logic [2:0] REG_REPLACE_EN = 3'd1;
  localparam logic [2:0] REG_TEXT_LEN   = 3'd2;
  localparam logic [2:0] REG_TEXT_LOW   = 3'd3;
  localparam logic [2:0] REG_TEXT_MID   = 3'd4;
  localparam logic [2:0] REG_TEXT_HIGH  = 3'd5;
  localparam logic [2:0] REG_MAX_SIZE   = 3'd6;

  localparam logic [1:0] MODE_BYTE = 2'd0;
  localparam logic [1:0] MODE_HELD = 2'd1;
  localparam logic [1:0] MODE_REPL = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       file_end;
  } out_word_t;

  typedef struct packed {
    logic [31:0] target_frame_id;
    logic        replace_enable;
    logic [4:0]  text_length;
    logic [63:0] text_bytes_low;
    logic [63:0] text_bytes_mid;
    logic [63:0] text_bytes_high;
    logic [30:0] max_frame_size;
  } cfg_t;

  typedef logic [FRAME_HDR_LEN-1:0][7:0] hdr_t;

  // one burst of result bytes caused by one input word
  typedef struct packed {
    logic [1:0] mode;
    logic [5:0] count;
    logic [7:0] data;
    hdr_t       hdr;
    logic       last;
  } desc_t;

endpackage

`default_nettype wire

// ===== design/id3ftr_regs.sv =====
`default_nettype none

module id3ftr_regs import id3ftr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[CFG_AW-1:3];
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_frame_id <= TARGET_ID_RST;
      cfg_r.replace_enable  <= 1'b0;
      cfg_r.text_length     <= '0;
      cfg_r.text_bytes_low  <= '0;
      cfg_r.text_bytes_mid  <= '0;
      cfg_r.text_bytes_high <= '0;
      cfg_r.max_frame_size  <= MAX_SIZE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TARGET_ID:  cfg_r.target_frame_id <= pwdata[31:0];
        REG_REPLACE_EN: cfg_r.replace_enable  <= pwdata[0];
        REG_TEXT_LEN:   cfg_r.text_length     <= pwdata[4:0];
        REG_TEXT_LOW:   cfg_r.text_bytes_low  <= pwdata;
        REG_TEXT_MID:   cfg_r.text_bytes_mid  <= pwdata;
        REG_TEXT_HIGH:  cfg_r.text_bytes_high <= pwdata;
        REG_MAX_SIZE:   cfg_r.max_frame_size  <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TARGET_ID:  prdata = {32'd0, cfg_r.target_frame_id};
      REG_REPLACE_EN: prdata = {63'd0, cfg_r.replace_enable};
      REG_TEXT_LEN:   prdata = {59'd0, cfg_r.text_length};
      REG_TEXT_LOW:   prdata = cfg_r.text_bytes_low;
      REG_TEXT_MID:   prdata = cfg_r.text_bytes_mid;
      REG_TEXT_HIGH:  prdata = cfg_r.text_bytes_high;
      REG_MAX_SIZE:   prdata = {33'd0, cfg_r.max_frame_size};
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/id3ftr_parse.sv =====
`default_nettype none

module id3ftr_parse import id3ftr_pkg::*; #(
  parameter int MAX_TEXT = MAX_TEXT_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     take,
  input  in_word_t in_data,
  input  cfg_t     cfg,
  output logic     desc_valid,
  output desc_t    desc
);

  localparam logic [2:0] PH_TAG_HDR   = 3'd0;
  localparam logic [2:0] PH_FRAME_HDR = 3'd1;
  localparam logic [2:0] PH_COPY_DATA = 3'd2;
  localparam logic [2:0] PH_DROP_DATA = 3'd3;
  localparam logic [2:0] PH_PASS      = 3'd4;

  logic [2:0]  phase_r, phase_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [30:0] rem_r, rem_nxt;
  hdr_t        hdr_r, hdr_nxt;

  hdr_t        hdr_w;
  logic [3:0]  cnt_inc;
  logic [31:0] size;
  logic [31:0] id;
  logic        size_bad;
  logic [4:0]  len;
  logic [30:0] rem_dec;
  logic        emit;

  always_comb begin
    hdr_w = hdr_r;
    if (cnt_r < 4'(FRAME_HDR_LEN)) begin
      hdr_w[cnt_r] = in_data.in_byte;
    end
    cnt_inc  = cnt_r + 4'd1;
    id       = {hdr_w[0], hdr_w[1], hdr_w[2], hdr_w[3]};
    size     = {hdr_w[4], hdr_w[5], hdr_w[6], hdr_w[7]};
    size_bad = (size == 32'd0) || size[31] || (size[30:0] > cfg.max_frame_size);
    len      = (cfg.text_length > 5'(MAX_TEXT)) ? 5'(MAX_TEXT) : cfg.text_length;
    rem_dec  = (rem_r != '0) ? rem_r - 31'd1 : rem_r;

    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    rem_nxt    = rem_r;
    hdr_nxt    = hdr_r;
    emit       = 1'b0;
    desc.mode  = MODE_BYTE;
    desc.count = 6'd1;

    case (phase_r)
      PH_TAG_HDR: begin
        emit    = 1'b1;
        cnt_nxt = cnt_inc;
        if (cnt_inc >= 4'(TAG_HDR_LEN)) begin
          cnt_nxt   = '0;
          phase_nxt = PH_FRAME_HDR;
        end
      end
      PH_FRAME_HDR: begin
        hdr_nxt = hdr_w;
        cnt_nxt = cnt_inc;
        if (cnt_inc == 4'(FRAME_HDR_LEN)) begin
          cnt_nxt    = '0;
          emit       = 1'b1;
          desc.mode  = MODE_HELD;
          desc.count = 6'(FRAME_HDR_LEN);
          rem_nxt    = size[30:0];
          if (size_bad) begin
            phase_nxt = PH_PASS;
            rem_nxt   = rem_r;
          end else if (cfg.replace_enable && (id == cfg.target_frame_id)) begin
            desc.mode  = MODE_REPL;
            desc.count = 6'(FRAME_HDR_LEN + 1) + {1'b0, len};
            phase_nxt  = PH_DROP_DATA;
          end else begin
            phase_nxt = PH_COPY_DATA;
          end
        end else if (in_data.in_last) begin
          // truncated header goes out as collected
          emit       = 1'b1;
          desc.mode  = MODE_HELD;
          desc.count = {2'b00, cnt_inc};
        end
      end
      PH_COPY_DATA, PH_DROP_DATA: begin
        emit    = (phase_r == PH_COPY_DATA);
        rem_nxt = rem_dec;
        if (rem_dec == '0) begin
          cnt_nxt   = '0;
          phase_nxt = PH_FRAME_HDR;
        end
      end
      default: begin
        emit = 1'b1;
      end
    endcase

    if (in_data.in_last) begin
      phase_nxt = PH_TAG_HDR;
      cnt_nxt   = '0;
      rem_nxt   = '0;
    end

    desc.data  = in_data.in_byte;
    desc.hdr   = hdr_w;
    desc.last  = in_data.in_last;
    desc_valid = take & emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TAG_HDR;
      cnt_r   <= '0;
      rem_r   <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      rem_r   <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hdr_r <= hdr_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/id3ftr_emit.sv =====
`default_nettype none

module id3ftr_emit import id3ftr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      desc_valid,
  input  desc_t     desc_in,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  logic      d_valid_r;
  desc_t     d_r;
  logic [5:0] idx_r;
  logic      out_valid_r;
  out_word_t out_r;

  logic       load_out;
  logic       step;
  logic       final_byte;
  logic [7:0] sel_byte;
  logic [4:0] ti;
  logic [5:0] nsize;
  logic [TEXT_SLOTS-1:0][7:0] text_arr;

  assign load_out   = !out_valid_r || out_ready;
  assign step       = d_valid_r && load_out;
  assign final_byte = (idx_r == d_r.count - 6'd1);
  assign in_ready   = !d_valid_r || (step && final_byte);
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;

  assign text_arr = {cfg.text_bytes_high, cfg.text_bytes_mid, cfg.text_bytes_low};
  assign ti       = 5'(idx_r - 6'(FRAME_HDR_LEN + 1));
  assign nsize    = d_r.count - 6'(FRAME_HDR_LEN);

  always_comb begin
    case (d_r.mode)
      MODE_BYTE: sel_byte = d_r.data;
      MODE_HELD: begin
        sel_byte = (idx_r < 6'(FRAME_HDR_LEN)) ? d_r.hdr[idx_r[3:0]] : PAD_BYTE;
      end
      MODE_REPL: begin
        if (idx_r < 6'd4) begin
          sel_byte = d_r.hdr[idx_r[3:0]];
        end else if (idx_r == 6'd7) begin
          sel_byte = {2'b00, nsize};
        end else if (idx_r == 6'd8 || idx_r == 6'd9) begin
          sel_byte = d_r.hdr[idx_r[3:0]];
        end else if (idx_r <= 6'd10) begin
          sel_byte = PAD_BYTE;
        end else begin
          sel_byte = (ti < 5'(TEXT_SLOTS)) ? text_arr[ti] : PAD_BYTE;
        end
      end
      default: sel_byte = PAD_BYTE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r   <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        d_valid_r <= desc_valid;
        idx_r     <= '0;
      end else if (step) begin
        idx_r <= idx_r + 6'd1;
      end
      if (load_out) begin
        out_valid_r <= d_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && desc_valid) begin
      d_r <= desc_in;
    end
    if (step) begin
      out_r.out_byte <= sel_byte;
      out_r.run_end  <= final_byte;
      out_r.file_end <= final_byte & d_r.last;
    end
  end

endmodule

`default_nettype wire

// ===== design/id3_frame_text_rewriter_unit.sv =====
// Streaming frame rewriter for tagged audio files: takes one file byte per word and
// gives the rewritten file one byte per word. Copied, passed and tag-header bytes pass
// through the descriptor and output byte registers, at one byte per cycle while the
// output is not stalled; dropped data bytes and held frame-header bytes are taken at
// one per cycle while in_ready is high, with no result. A completed frame header
// releases a burst of 10 bytes, or 11 plus the text length for a replaced frame, from
// the single output byte register; while such a burst drains, in_ready stays low until
// its final byte is being loaded. Write configuration only while the block is idle.
`default_nettype none

module id3_frame_text_rewriter_unit import id3ftr_pkg::*; #(
  parameter int MAX_TEXT = MAX_TEXT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_word_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  cfg_t  cfg;
  logic  take;
  logic  desc_valid;
  desc_t desc;

  assign take = in_valid & in_ready;

  id3ftr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  id3ftr_parse #(
    .MAX_TEXT (MAX_TEXT)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .in_data    (in_data),
    .cfg        (cfg),
    .desc_valid (desc_valid),
    .desc       (desc)
  );

  id3ftr_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .desc_valid (desc_valid),
    .desc_in    (desc),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

// ===== design/id3ftr_checker.sv =====
`default_nettype none

`include "id3_frame_text_rewriter_unit_assert.svh"

module id3ftr_checker import id3ftr_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data,
  input logic      pready
);

  `ID3FTR_ASSERT_ALWAYS(a_pready_high, pready == 1'b1, "pready dropped")
  `ID3FTR_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "output word changed while stalled")
  `ID3FTR_ASSERT(a_file_end_run_end, out_valid && out_data.file_end |-> out_data.run_end, "file end without run end")
  `ID3FTR_ASSERT(a_burst_gapless, out_valid && out_ready && !out_data.run_end |=> out_valid, "gap inside a burst")

endmodule

bind id3_frame_text_rewriter_unit id3ftr_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .pready    (pready)
);

`default_nettype wire
